// ----- sv/ilir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 6;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_GET    = 3'd3,
		CMD_SET    = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// the operation that every cell of the row performs
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_WRITE,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage

// ----- sv/ilir_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_req_if / ilir_rsp_if
// Valid/ready channels carrying list requests and their results.
// ----------------------------------------------------------------------------
interface ilir_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [5:0]         position;
	logic signed [31:0] data_word;

	modport source (output valid, cmd, position, data_word, input ready);
	modport sink (input valid, cmd, position, data_word, output ready);
endinterface

interface ilir_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] read_word;
	logic [6:0]         count;

	modport source (output valid, status, read_word, count, input ready);
	modport sink (input valid, status, read_word, count, output ready);
endinterface

// ----- sv/ilir_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_cell
// One list entry; loads a new word, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module ilir_cell
	import ilir_pkg::*;
#(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [IW-1:0]     idx,
	input  logic [WORD_W-1:0] left_word,
	input  logic [WORD_W-1:0] right_word,
	output logic [WORD_W-1:0] word
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WRITE: begin
				if (MY_IDX == idx) word_q <= ctrl.word;
			end
			OP_SHIFT_UP: begin
				if (MY_IDX == idx) word_q <= ctrl.word;
				else if (MY_IDX > idx) word_q <= left_word;
			end
			OP_SHIFT_DOWN: begin
				if (MY_IDX >= idx) word_q <= right_word;
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;

endmodule

// ----- sv/indexed_list_insert_remove_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Bounded ordered list of 32-bit words held in a row of cells.
// The result is registered when its request is accepted.
// One request per cycle, stalled while a result waits; the cells shift in parallel.
// Reset: the count clears at once, stored words stay undefined until written.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_top
	import ilir_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ilir_req_if.sink   req,
	ilir_rsp_if.source rsp
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int CMPW  = (CW > POS_W) ? CW : POS_W;
	localparam int NREAD = (ENTRIES < 64) ? ENTRIES : 64;
	localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [WORD_W-1:0]   read_word_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                accept;
	logic                in_range;
	logic                full;
	logic [IW-1:0]       pos_idx;
	logic [IW-1:0]       tail_idx;
	logic [WORD_W-1:0]   sel_word;
	logic [STATUS_W-1:0] status_d;
	logic [WORD_W-1:0]   read_word_d;
	logic [CW-1:0]       count_d;
	cell_op_t            op_d;
	logic [IW-1:0]       idx_d;
	cell_ctrl_t          ctrl;
	logic [WORD_W-1:0]   cell_word [ENTRIES];

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign in_range = CMPW'(req.position) < CMPW'(count_q);
	assign full     = count_q == FULL_COUNT;
	assign pos_idx  = IW'(CMPW'(req.position));
	assign tail_idx = count_q[IW-1:0];

	// only the first 64 entries can be named by a position
	always_comb begin
		sel_word = '0;
		for (int k = 0; k < NREAD; k++) begin
			if (req.position == POS_W'(k)) sel_word = cell_word[k];
		end
	end

	always_comb begin
		status_d    = ST_DONE;
		read_word_d = '0;
		count_d     = count_q;
		op_d        = OP_HOLD;
		idx_d       = pos_idx;
		case (req.cmd)
			CMD_APPEND, CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (req.cmd == CMD_INSERT && in_range) begin
					op_d    = OP_SHIFT_UP;
					count_d = count_q + 1'b1;
				end else begin
					op_d    = OP_WRITE;
					idx_d   = tail_idx;
					count_d = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					read_word_d = sel_word;
					op_d        = OP_SHIFT_DOWN;
					count_d     = count_q - 1'b1;
				end
			end
			CMD_GET: begin
				if (!in_range) status_d = ST_RANGE;
				else read_word_d = sel_word;
			end
			CMD_SET: begin
				if (!in_range) status_d = ST_RANGE;
				else op_d = OP_WRITE;
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign ctrl.op   = accept ? op_d : OP_HOLD;
	assign ctrl.word = req.data_word;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_word[i-1];
		end
		if (i == ENTRIES - 1) begin : g_last
			assign right_w = cell_word[i];
		end else begin : g_right
			assign right_w = cell_word[i+1];
		end
		ilir_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (idx_d),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			read_word_q <= read_word_d;
			out_count_q <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.read_word = read_word_q;
	assign rsp.count     = out_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("list count above capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request left no result");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == CMD_CLEAR |=> count_q == '0)
		else $error("clear did not empty the list");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_FULL |-> count_q == FULL_COUNT)
		else $error("full status with room left");
`endif

endmodule
